@@ src/hjd_pkg.sv @@
// Shared types and codes for the headset jack and hook detector.
// No dependencies; imported by every module of the block.
package hjd_pkg;

   // Kind of an input transaction
   typedef enum logic [1:0] {
      KIND_JACK  = 2'd0,
      KIND_PROBE = 2'd1,
      KIND_HOOK  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // Event code of a result transaction
   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_JACK  = 3'd1,
      EV_MIC   = 3'd2,
      EV_HOOK  = 3'd3,
      EV_PROBE = 3'd4
   } event_type;

   // Plug class
   typedef enum logic [1:0] {
      CLASS_NOTHING   = 2'd0,
      CLASS_HEADSET   = 2'd1,
      CLASS_HEADPHONE = 2'd2
   } class_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_JACK_IN_HIGH   = 2'd0;
   localparam logic [1:0] CSR_KEY_PRESS_HIGH = 2'd1;
   localparam logic [1:0] CSR_HOOK_PRESENT   = 2'd2;

   typedef struct packed {
      logic jack_in_high;
      logic key_press_high;
      logic hook_present;
   } cfg_type;

   typedef struct packed {
      logic      jack_in;
      logic      button_down;
      logic      hook_enabled;
      logic      mic_found;
      class_type jack_class;
   } state_type;

   typedef struct packed {
      event_type event_res;
      logic      report_state;
      class_type jack_class;
   } result_type;

endpackage

@@ src/hjd_step.sv @@
// Next-state and result logic for one detector transaction.
// Depends on hjd_pkg; purely combinational, used by the top level.
module hjd_step
   import hjd_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  state,
   input  kind_type   kind,
   input  logic       level_first,
   input  logic       level_second,
   output state_type  state_next,
   output result_type result
);

   logic now_in;
   logic key_down;

   // Map pin levels through the polarity settings
   assign now_in   = cfg.jack_in_high ? level_first : ~level_first;
   assign key_down = (level_first == cfg.key_press_high);

   always_comb begin
      state_next          = state;
      result.event_res    = EV_NONE;
      result.report_state = 1'b0;
      unique case (kind)
         KIND_JACK: begin
            // Accept only agreeing samples that change the jack state
            if ((level_first == level_second) && (now_in != state.jack_in)) begin
               state_next.jack_in = now_in;
               if (now_in) begin
                  state_next.jack_class = CLASS_HEADPHONE;
                  if (cfg.hook_present) begin
                     result.event_res = EV_PROBE;
                  end else begin
                     result.event_res    = EV_JACK;
                     result.report_state = 1'b1;
                  end
               end else begin
                  state_next.button_down  = 1'b0;
                  state_next.hook_enabled = 1'b0;
                  state_next.jack_class   = CLASS_NOTHING;
                  result.event_res        = EV_JACK;
               end
            end
         end
         KIND_PROBE: begin
            // Idle hook level means a mic is on the plug
            if (state.jack_in && cfg.hook_present) begin
               if (!key_down) begin
                  state_next.mic_found    = 1'b1;
                  state_next.hook_enabled = 1'b1;
                  state_next.button_down  = 1'b0;
                  state_next.jack_class   = CLASS_HEADSET;
               end else begin
                  state_next.mic_found  = 1'b0;
                  state_next.jack_class = CLASS_HEADPHONE;
               end
               result.event_res    = EV_MIC;
               result.report_state = ~key_down;
            end
         end
         KIND_HOOK: begin
            // Report button edges while the hook is live
            if (state.jack_in && state.hook_enabled && (key_down != state.button_down)) begin
               state_next.button_down = key_down;
               result.event_res       = EV_HOOK;
               result.report_state    = key_down;
            end
         end
         default: begin
            // Unused kind: drop
         end
      endcase
      result.jack_class = state_next.jack_class;
   end

endmodule

@@ src/headset_jack_and_hook_detector_unit.sv @@
// Top level of the headset jack and hook detector.
// Depends on hjd_pkg and hjd_step.
// An accepted request's response is registered in the output register in the cycle after acceptance.
// Throughput: one transaction per cycle; the output register is refilled in the same
// cycle it drains, so only a held response stalls the request side.
// Reset (synchronous): state unplugged, class nothing, registers at 1, no response pending.
module headset_jack_and_hook_detector_unit
   import hjd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [0] level_first, [1] level_second, [7:2] zero
   input  logic [1:0] req_tuser,   // [1:0] kind
   // response channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] report_state, [2:1] jack_class, [7:3] zero
   output logic [2:0] rsp_tuser,   // [2:0] event_res
   // configuration port
   input  logic       csr_wen,
   input  logic [1:0] csr_index,
   input  logic       csr_wdata
);

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       req_accept;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;

   hjd_step u_step (
      .cfg          (cfg_ff),
      .state        (state_ff),
      .kind         (kind_type'(req_tuser)),
      .level_first  (req_tdata[0]),
      .level_second (req_tdata[1]),
      .state_next   (state_in),
      .result       (result_in)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{jack_in_high: 1'b1, key_press_high: 1'b1, hook_present: 1'b1};
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_JACK_IN_HIGH:   cfg_ff.jack_in_high   <= csr_wdata;
            CSR_KEY_PRESS_HIGH: cfg_ff.key_press_high <= csr_wdata;
            CSR_HOOK_PRESENT:   cfg_ff.hook_present   <= csr_wdata;
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // Advance the detector state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{jack_in: 1'b0, button_down: 1'b0, hook_enabled: 1'b0,
                       mic_found: 1'b0, jack_class: CLASS_NOTHING};
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Output register: load on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = result_ff.event_res;
   assign rsp_tdata  = {5'd0, result_ff.jack_class, result_ff.report_state};

endmodule

@@ src/hjd_checker.sv @@
// Port-level checks for the headset jack and hook detector.
// Depends on hjd_pkg; bound to headset_jack_and_hook_detector_unit below.
module hjd_checker
   import hjd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser
);

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Every accepted request yields a response on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no response");

   // No event and probe requests carry a zero report
   a_quiet_report: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_NONE || rsp_tuser == EV_PROBE) |-> !rsp_tdata[0])
      else $error("report set on a silent event");

   // A jack report agrees with the class it leaves behind
   a_jack_class: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_JACK |->
         (rsp_tdata[0] ? rsp_tdata[2:1] == CLASS_HEADPHONE : rsp_tdata[2:1] == CLASS_NOTHING))
      else $error("jack report and class disagree");

   // Reset leaves no response pending
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind headset_jack_and_hook_detector_unit hjd_checker u_hjd_checker (.*);

@@ tb/sv/tb_headset_jack_and_hook_detector_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for headset_jack_and_hook_detector_unit.
// Depends on hjd_pkg; a scoreboard class predicts each response and checks
// it, and plain tasks drive the request and configuration ports.
module tb_headset_jack_and_hook_detector_unit;
   import hjd_pkg::*;

   // Tracks plug, mic and hook state and holds the reports still owed
   class hjd_scoreboard;
      cfg_type    cfg;
      state_type  jack_state;
      result_type pending_reports[$];
      int         errors;

      function new();
         cfg = '1;
         jack_state = '0;
         errors = 0;
      endfunction

      // Work out the report caused by one event and advance the state
      function result_type jack_hook_outcome(kind_type kind, logic lvl_a, logic lvl_b);
         result_type r;
         logic       plugged;
         logic       pressed;
         r.event_res = EV_NONE;
         r.report_state = 1'b0;
         case (kind)
            KIND_JACK: begin
               // disagreeing samples are a bounce: drop the event
               if (lvl_a == lvl_b) begin
                  plugged = cfg.jack_in_high ? lvl_a : !lvl_a;
                  if (plugged != jack_state.jack_in) begin
                     jack_state.jack_in = plugged;
                     if (plugged) begin
                        jack_state.jack_class = CLASS_HEADPHONE;
                        if (cfg.hook_present) begin
                           r.event_res = EV_PROBE;
                        end else begin
                           r.event_res = EV_JACK;
                           r.report_state = 1'b1;
                        end
                     end else begin
                        // removal releases the key and disables the hook
                        jack_state.button_down = 1'b0;
                        jack_state.hook_enabled = 1'b0;
                        jack_state.jack_class = CLASS_NOTHING;
                        r.event_res = EV_JACK;
                     end
                  end
               end
            end
            KIND_PROBE: begin
               if (jack_state.jack_in && cfg.hook_present) begin
                  // idle hook level means a mic is present
                  if (lvl_a != cfg.key_press_high) begin
                     jack_state.mic_found = 1'b1;
                     jack_state.hook_enabled = 1'b1;
                     jack_state.button_down = 1'b0;
                     jack_state.jack_class = CLASS_HEADSET;
                  end else begin
                     jack_state.mic_found = 1'b0;
                     jack_state.jack_class = CLASS_HEADPHONE;
                  end
                  r.event_res = EV_MIC;
                  r.report_state = jack_state.mic_found;
               end
            end
            KIND_HOOK: begin
               if (jack_state.jack_in && jack_state.hook_enabled) begin
                  pressed = (lvl_a == cfg.key_press_high);
                  if (pressed != jack_state.button_down) begin
                     jack_state.button_down = pressed;
                     r.event_res = EV_HOOK;
                     r.report_state = pressed;
                  end
               end
            end
            default: ;
         endcase
         r.jack_class = jack_state.jack_class;
         return r;
      endfunction

      function void note_request(kind_type kind, logic lvl_a, logic lvl_b);
         pending_reports.push_back(jack_hook_outcome(kind, lvl_a, lvl_b));
      endfunction

      // Compare one response transaction with the oldest expected report
      function void check_report(logic [2:0] ev, logic rs, logic [1:0] cls);
         result_type exp_r;
         if (pending_reports.size() == 0) begin
            $error("response transaction with no request pending");
            errors++;
            return;
         end
         exp_r = pending_reports.pop_front();
         if (ev !== exp_r.event_res) begin
            $error("event_res mismatch: expected %0d, actual %0d", exp_r.event_res, ev);
            errors++;
         end
         if (rs !== exp_r.report_state) begin
            $error("report_state mismatch: expected %0d, actual %0d",
                   exp_r.report_state, rs);
            errors++;
         end
         if (cls !== exp_r.jack_class) begin
            $error("jack_class mismatch: expected %0d, actual %0d", exp_r.jack_class, cls);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       csr_wen = 1'b0;
   logic [1:0] csr_index = '0;
   logic       csr_wdata = 1'b0;

   logic          steady = 1'b0;   // no idling on either side while set
   int            items_sent = 0;
   hjd_scoreboard sb = new();

   headset_jack_and_hook_detector_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Accept responses with random stalls and check each one
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_report(rsp_tuser, rsp_tdata[0], rsp_tdata[2:1]);
         end
         rsp_tready <= steady || ($urandom_range(0, 99) >= 6);
      end
   end

   // Send one request transaction, idling first at random
   task automatic send_event(kind_type kind, logic lvl_a, logic lvl_b);
      if (!steady && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'b0, lvl_b, lvl_a};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, lvl_a, lvl_b);
      items_sent++;
   endtask

   task automatic send_noise();
      send_event(kind_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
   endtask

   // Hold the request side until every expected report has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending_reports.size() != 0);
   endtask

   // Write all three registers; the block must be idle
   task automatic write_config(cfg_type c);
      csr_wen <= 1'b1;
      csr_index <= CSR_JACK_IN_HIGH;
      csr_wdata <= c.jack_in_high;
      @(posedge clock);
      csr_index <= CSR_KEY_PRESS_HIGH;
      csr_wdata <= c.key_press_high;
      @(posedge clock);
      csr_index <= CSR_HOOK_PRESENT;
      csr_wdata <= c.hook_present;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.cfg = c;
   endtask

   // Plug in, maybe probe, press and release the key, then maybe unplug
   task automatic run_session();
      logic plug_lvl;
      logic idle_lvl;
      int   n;
      plug_lvl = sb.cfg.jack_in_high;
      idle_lvl = !sb.cfg.key_press_high;
      send_event(KIND_JACK, plug_lvl, plug_lvl);
      if ($urandom_range(0, 3) != 0) begin
         send_event(KIND_PROBE, ($urandom_range(0, 3) != 0) ? idle_lvl : !idle_lvl,
                    1'($urandom_range(0, 1)));
      end
      n = $urandom_range(1, 10);
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) begin
            send_noise();
         end else begin
            send_event(KIND_HOOK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
      if ($urandom_range(0, 4) != 0) begin
         send_event(KIND_JACK, !plug_lvl, !plug_lvl);
      end
   endtask

   // Main stimulus
   initial begin
      int phase_start;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_config('1);

      // Directed: bounces, ignored events, insertion with probe, key, removal
      send_event(KIND_JACK, 1'b1, 1'b0);
      send_event(KIND_JACK, 1'b0, 1'b1);
      send_event(KIND_JACK, 1'b0, 1'b0);
      send_event(KIND_HOOK, 1'b1, 1'b0);
      send_event(KIND_PROBE, 1'b0, 1'b0);
      send_event(KIND_JACK, 1'b1, 1'b1);
      send_event(KIND_HOOK, 1'b1, 1'b1);
      send_event(KIND_PROBE, 1'b1, 1'b0);
      send_event(KIND_PROBE, 1'b0, 1'b1);
      send_event(KIND_HOOK, 1'b0, 1'b0);
      send_event(KIND_HOOK, 1'b1, 1'b0);
      send_event(KIND_HOOK, 1'b0, 1'b1);
      send_event(KIND_HOOK, 1'b1, 1'b1);
      send_event(KIND_NONE, 1'b0, 1'b0);
      send_event(KIND_JACK, 1'b1, 1'b1);
      send_event(KIND_JACK, 1'b0, 1'b0);
      send_event(KIND_NONE, 1'b1, 1'b1);

      // Directed: inverted polarities and no hook line
      drain_responses();
      write_config('0);
      send_event(KIND_JACK, 1'b0, 1'b0);
      send_event(KIND_PROBE, 1'b1, 1'b0);
      send_event(KIND_HOOK, 1'b0, 1'b0);
      send_event(KIND_JACK, 1'b1, 1'b1);

      // Random: one phase per register setting
      for (int p = 0; p < 8; p++) begin
         drain_responses();
         write_config(cfg_type'(p[2:0]));
         steady = (p == 5 || p == 6);
         phase_start = items_sent;
         while (items_sent - phase_start < 100) begin
            if (p == 3 && items_sent - phase_start == 50) begin
               drain_responses();
            end
            if ($urandom_range(0, 9) < 7) begin
               run_session();
            end else begin
               send_noise();
            end
         end
      end
      steady = 1'b0;

      drain_responses();
      repeat (4) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #(2_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ files.f @@
src/hjd_pkg.sv
src/hjd_step.sv
src/headset_jack_and_hook_detector_unit.sv
src/hjd_checker.sv
tb/sv/tb_headset_jack_and_hook_detector_unit.sv
